// ----- hdl/csd_pkg.sv -----
`default_nettype none

package csd_pkg;

   // Defaults for the top-level parameters
   localparam int NUM_SIGNALS_DEF    = 4;
   localparam int MAX_DATA_BYTES_DEF = 8;

   // Fixed geometry of the slot store and the frame
   localparam int SLOT_STORE = 4;
   localparam int SLOT_W     = 2;
   localparam int ID_W       = 29;
   localparam int DLC_W      = 4;
   localparam int DATA_W     = 64;
   localparam int BYTE_W     = 8;
   localparam int DATA_BYTES = 8;
   localparam int BYTE_IDX_W = 3;
   localparam int LEN_W      = 4;
   localparam int HALF_W     = 32;
   localparam int DEF_W      = 38;
   localparam int CAL_W      = 64;
   localparam int CSR_IDX_W  = 3;

   // Register map: definitions first, calibrations from this index on
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_BASE = 3'd4;

   localparam int JOB_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   typedef struct packed {
      logic                  enable;
      logic                  msb_first;
      logic [LEN_W-1:0]      length;
      logic [BYTE_IDX_W-1:0] first_byte;
      logic [ID_W-1:0]       can_id;
   } sig_def_type;

   typedef struct packed {
      logic signed [HALF_W-1:0] offset;
      logic [HALF_W-1:0]        scale;
   } sig_cal_type;

   localparam sig_cal_type CAL_RESET = '{offset: '0, scale: 32'h0001_0000};

   typedef struct packed {
      logic [DATA_W-1:0]     frame_data;
      logic [SLOT_STORE-1:0] match;
   } job_type;

   typedef struct packed {
      logic [SLOT_W-1:0]        signal_slot;
      logic [DATA_W-1:0]        raw_value;
      logic signed [DATA_W-1:0] scaled_value;
      logic                     last;
   } rsp_type;

   localparam logic [DATA_W-1:0] SCALED_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

`default_nettype wire

// ----- hdl/csd_fifo.sv -----
`default_nettype none

module csd_fifo import csd_pkg::*; #(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = JOB_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/csd_front.sv -----
`default_nettype none

module csd_front import csd_pkg::*; #(
   parameter int NUM_SIGNALS    = NUM_SIGNALS_DEF,
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
   input  logic              req_push,
   input  logic [ID_W-1:0]   req_can_id,
   input  logic [DLC_W-1:0]  req_length_code,
   input  logic [DATA_W-1:0] req_frame_data,
   output logic              req_full,
   input  sig_def_type       sig_def [SLOT_STORE],
   input  logic              job_full,
   output logic              job_push,
   output job_type           job_data
);

   localparam logic [DLC_W-1:0] MAX_DLC = DLC_W'(MAX_DATA_BYTES);

   logic [DLC_W-1:0]      dlc_eff;
   logic [SLOT_STORE-1:0] match;
   logic [LEN_W:0]        span;

   // Clamp the length code to the data size
   assign dlc_eff = (req_length_code > MAX_DLC) ? MAX_DLC : req_length_code;

   always_comb begin
      match = '0;
      span  = '0;
      for (int k = 0; k < SLOT_STORE; k++) begin
         span = {2'b00, sig_def[k].first_byte} + {1'b0, sig_def[k].length};
         if (k < NUM_SIGNALS) begin
            match[k] = sig_def[k].enable && (sig_def[k].can_id == req_can_id) &&
                       (span <= {1'b0, dlc_eff});
         end
      end
   end

   // Drop frames that match no slot; they produce no results
   assign req_full            = job_full;
   assign job_push            = req_push && !job_full && (match != '0);
   assign job_data.frame_data = req_frame_data;
   assign job_data.match      = match;

endmodule

`default_nettype wire

// ----- hdl/csd_back.sv -----
`default_nettype none

module csd_back import csd_pkg::*; #(
   parameter int NUM_SIGNALS = NUM_SIGNALS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_empty,
   input  job_type     job_data,
   output logic        job_pop,
   input  sig_def_type sig_def [SLOT_STORE],
   input  sig_cal_type sig_cal [SLOT_STORE],
   input  logic        rsp_full,
   output logic        rsp_push,
   output rsp_type     rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_GATHER = 4'b0010,
      ST_MUL    = 4'b0100,
      ST_ADD    = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [DATA_W-1:0]     data_ff;
   logic [SLOT_STORE-1:0] rem_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic                  last_ff;
   logic [DATA_W-1:0]     raw_ff, raw_in;
   logic [DATA_W-1:0]     p_lo_ff, p_lo_in;
   logic [DATA_W-1:0]     p_hi_ff, p_hi_in;

   logic [SLOT_W-1:0]     pick_slot;
   logic                  pick_found;
   logic [SLOT_STORE-1:0] pick_clear;
   sig_def_type           pick_def;
   sig_cal_type           cur_cal;
   logic [BYTE_IDX_W-1:0] pos;
   logic [BYTE_IDX_W-1:0] jj;
   logic [DATA_W:0]       low_sum;
   logic                  prod_over;
   logic [DATA_W+1:0]     total;
   logic                  sat;

   // Pick the lowest remaining slot
   always_comb begin
      pick_slot  = '0;
      pick_found = 1'b0;
      for (int k = 0; k < SLOT_STORE; k++) begin
         if (rem_ff[k] && !pick_found) begin
            pick_slot  = SLOT_W'(k);
            pick_found = 1'b1;
         end
      end
   end

   assign pick_clear = rem_ff & ~(SLOT_STORE'(1) << pick_slot);
   assign pick_def   = sig_def[pick_slot];
   assign cur_cal    = sig_cal[slot_ff];

   // Gather bytes: result byte j comes from frame byte start + j (little) or
   // start + len - 1 - j (big), wrapping within the frame
   always_comb begin
      raw_in = '0;
      pos    = '0;
      jj     = '0;
      for (int j = 0; j < DATA_BYTES; j++) begin
         jj  = BYTE_IDX_W'(j);
         pos = pick_def.msb_first ?
               (pick_def.first_byte + pick_def.length[BYTE_IDX_W-1:0] - 3'd1 - jj) :
               (pick_def.first_byte + jj);
         if (LEN_W'(j) < pick_def.length) begin
            raw_in[BYTE_W*j +: BYTE_W] = data_ff[BYTE_W*pos +: BYTE_W];
         end
      end
   end

   // Two 32x32 partial products
   assign p_lo_in = raw_ff[HALF_W-1:0] * cur_cal.scale;
   assign p_hi_in = raw_ff[DATA_W-1:HALF_W] * cur_cal.scale;

   // Combine, add the offset, saturate high
   assign low_sum   = {1'b0, p_lo_ff} + {1'b0, p_hi_ff[HALF_W-1:0], {HALF_W{1'b0}}};
   assign prod_over = (p_hi_ff[DATA_W-1:HALF_W] != '0) || low_sum[DATA_W];
   assign total     = {2'b00, low_sum[DATA_W-1:0]} +
                      {{(DATA_W-HALF_W+2){cur_cal.offset[HALF_W-1]}}, cur_cal.offset};
   assign sat       = prod_over || (!total[DATA_W+1] && (total[DATA_W] || total[DATA_W-1]));

   assign rsp_data.signal_slot  = slot_ff;
   assign rsp_data.raw_value    = raw_ff;
   assign rsp_data.scaled_value = sat ? SCALED_TOP : total[DATA_W-1:0];
   assign rsp_data.last         = last_ff;

   always_comb begin
      state_in = state_ff;
      job_pop  = 1'b0;
      rsp_push = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               state_in = ST_GATHER;
            end
         end
         ST_GATHER: state_in = ST_MUL;
         ST_MUL:    state_in = ST_ADD;
         ST_ADD: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = last_ff ? ST_IDLE : ST_GATHER;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         data_ff <= job_data.frame_data;
         rem_ff  <= job_data.match;
      end
      if (state_ff == ST_GATHER) begin
         slot_ff <= pick_slot;
         last_ff <= (pick_clear == '0);
         rem_ff  <= pick_clear;
         raw_ff  <= raw_in;
      end
      if (state_ff == ST_MUL) begin
         p_lo_ff <= p_lo_in;
         p_hi_ff <= p_hi_in;
      end
   end

   a_push_from_add: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (state_ff == ST_ADD) && !rsp_full)
      else $error("result pushed outside the add step or into a full queue");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> ({1'b0, rsp_data.signal_slot} < (SLOT_W+1)'(NUM_SIGNALS)))
      else $error("result for a slot beyond the configured count");

   a_gather_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GATHER) |-> (rem_ff != '0))
      else $error("gather step entered with no slot left");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_data.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after the final result");

endmodule

`default_nettype wire

// ----- hdl/can_signal_decoder_core.sv -----
`default_nettype none

// CAN signal decoder. Push one received frame (identifier, length code, eight
// data bytes) per request; pop one result per matching signal slot, in slot
// order, with last set on the final result of the frame. A frame that matches
// no slot gives no result. The front end classifies a frame in the cycle it is
// pushed and queues it (two frames deep); the back end then loads the frame
// and runs its three-step result sequencer per result (byte gather, 32x32
// partial products, offset add with saturation); the add step waits while the
// result queue is full. The back end takes the next frame only after the final
// result of the current one. Results wait in a two-deep queue, so the back end
// keeps working while the consumer stalls, until that queue fills.
// Write the slot registers only while no frame is in flight; csr_ready is
// always high.

module can_signal_decoder_core import csd_pkg::*; #(
   parameter int NUM_SIGNALS    = NUM_SIGNALS_DEF,
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // Frame requests
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [ID_W-1:0]          req_can_id,
   input  logic [DLC_W-1:0]         req_length_code,
   input  logic [DATA_W-1:0]        req_frame_data,
   // Results
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [SLOT_W-1:0]        rsp_signal_slot,
   output logic [DATA_W-1:0]        rsp_raw_value,
   output logic signed [DATA_W-1:0] rsp_scaled_value,
   output logic                     rsp_last,
   // Register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CAL_W-1:0]         csr_data
);

   localparam int JOB_W = $bits(job_type);
   localparam int RSP_W = $bits(rsp_type);

   sig_def_type def_ff [SLOT_STORE];
   sig_cal_type cal_ff [SLOT_STORE];

   logic             job_push, job_full, job_pop, job_empty;
   job_type          job_in, job_head;
   logic [JOB_W-1:0] job_q;

   logic             rsp_push, rsp_full;
   rsp_type          rsp_in, rsp_head;
   logic [RSP_W-1:0] rsp_q;

   // Slot registers: definitions below the calibration base, masked to width
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOT_STORE; k++) begin
            def_ff[k] <= '0;
            cal_ff[k] <= CAL_RESET;
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index < CSR_CAL_BASE) begin
            def_ff[csr_index[SLOT_W-1:0]] <= sig_def_type'(csr_data[DEF_W-1:0]);
         end else begin
            cal_ff[csr_index[SLOT_W-1:0]] <= sig_cal_type'(csr_data);
         end
      end
   end

   // Front end: clamp the length code, match slots, queue the frame
   csd_front #(
      .NUM_SIGNALS    (NUM_SIGNALS),
      .MAX_DATA_BYTES (MAX_DATA_BYTES)
   ) u_front (
      .req_push        (req_push),
      .req_can_id      (req_can_id),
      .req_length_code (req_length_code),
      .req_frame_data  (req_frame_data),
      .req_full        (req_full),
      .sig_def         (def_ff),
      .job_full        (job_full),
      .job_push        (job_push),
      .job_data        (job_in)
   );

   csd_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_q),
      .empty     (job_empty)
   );

   assign job_head = job_type'(job_q);

   // Back end: one result per matching slot
   csd_back #(
      .NUM_SIGNALS (NUM_SIGNALS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (job_head),
      .job_pop   (job_pop),
      .sig_def   (def_ff),
      .sig_cal   (cal_ff),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in)
   );

   // Hold finished results until popped
   csd_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_q),
      .empty     (rsp_empty)
   );

   assign rsp_head         = rsp_type'(rsp_q);
   assign rsp_signal_slot  = rsp_head.signal_slot;
   assign rsp_raw_value    = rsp_head.raw_value;
   assign rsp_scaled_value = rsp_head.scaled_value;
   assign rsp_last         = rsp_head.last;

endmodule

`default_nettype wire

// ----- tb/can_signal_decoder_core_test.sv -----
import csd_pkg::*;

class signal_book;
   sig_def_type defs[SLOT_STORE];
   sig_cal_type cals[SLOT_STORE];
   rsp_type     expected_signals[$];
   int unsigned failures;

   function new();
      int k;
      failures = 0;
      for (k = 0; k < SLOT_STORE; k++) begin
         defs[k] = '0;
         cals[k] = CAL_RESET;
      end
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CAL_W-1:0] data);
      if (idx < CSR_CAL_BASE) begin
         defs[idx[SLOT_W-1:0]] = data[DEF_W-1:0];
      end else begin
         cals[idx[SLOT_W-1:0]] = data;
      end
   endfunction

   function int outstanding();
      return expected_signals.size();
   endfunction

   // raw * scale + offset in Q.16, clamped at the top of the signed range
   function logic [DATA_W-1:0] scale_raw(logic [DATA_W-1:0] raw, sig_cal_type cal);
      logic [DATA_W+HALF_W-1:0] product;
      logic [DATA_W+1:0]        sum;
      product = {{HALF_W{1'b0}}, raw} * {{DATA_W{1'b0}}, cal.scale};
      if (product[DATA_W+HALF_W-1:DATA_W] != '0) begin
         return SCALED_TOP;
      end
      sum = {2'b00, product[DATA_W-1:0]} + {{(DATA_W-HALF_W+2){cal.offset[HALF_W-1]}}, cal.offset};
      if (!sum[DATA_W+1] && sum[DATA_W:DATA_W-1] != 2'b00) begin
         return SCALED_TOP;
      end
      return sum[DATA_W-1:0];
   endfunction

   function void note_frame(logic [ID_W-1:0] id, logic [DLC_W-1:0] dlc,
                            logic [DATA_W-1:0] data);
      int unsigned       k;
      int unsigned       i;
      int unsigned       pos;
      int unsigned       avail;
      int unsigned       start;
      int unsigned       len;
      logic [DATA_W-1:0] raw;
      rsp_type           held;
      bit                have_one;
      have_one = 0;
      avail = (dlc > DATA_BYTES) ? DATA_BYTES : dlc;
      for (k = 0; k < NUM_SIGNALS_DEF && k < SLOT_STORE; k++) begin
         start = defs[k].first_byte;
         len   = defs[k].length;
         if (!defs[k].enable || defs[k].can_id != id || start + len > avail) begin
            continue;
         end
         raw = '0;
         for (i = 0; i < len; i++) begin
            pos = defs[k].msb_first ? start + i : start + len - 1 - i;
            raw = {raw[DATA_W-BYTE_W-1:0], data[(pos % DATA_BYTES)*BYTE_W +: BYTE_W]};
         end
         if (have_one) begin
            expected_signals = {expected_signals, held};
         end
         held.signal_slot  = SLOT_W'(k);
         held.raw_value    = raw;
         held.scaled_value = scale_raw(raw, cals[k]);
         held.last         = 1'b0;
         have_one = 1;
      end
      if (have_one) begin
         held.last = 1'b1;
         expected_signals = {expected_signals, held};
      end
   endfunction

   task report(string what);
      if (failures < 100) begin
         $display("MISMATCH %s", what);
      end
      failures++;
   endtask

   task check_signal(logic [SLOT_W-1:0] slot, logic [DATA_W-1:0] raw,
                     logic [DATA_W-1:0] scaled, logic last);
      rsp_type want;
      if (expected_signals.size() == 0) begin
         report($sformatf("unexpected result: slot %0d raw %h scaled %h", slot, raw, scaled));
         return;
      end
      want = expected_signals.pop_front();
      if (slot !== want.signal_slot) begin
         report($sformatf("signal_slot got %0d want %0d", slot, want.signal_slot));
      end
      if (raw !== want.raw_value) begin
         report($sformatf("slot %0d raw_value got %h want %h", want.signal_slot, raw,
                          want.raw_value));
      end
      if (scaled !== want.scaled_value) begin
         report($sformatf("slot %0d scaled_value got %h want %h (raw %h)", want.signal_slot,
                          scaled, want.scaled_value, want.raw_value));
      end
      if (last !== want.last) begin
         report($sformatf("slot %0d last got %b want %b", want.signal_slot, last, want.last));
      end
   endtask
endclass

module can_signal_decoder_core_test;

   // Definitions sit at the bottom of the register map, calibrations above
   localparam logic [CSR_IDX_W-1:0] REG_DEF_BASE = '0;
   // Two queued frames with four matches each, plus the result queue, with margin
   localparam int DRAIN_CYCLES = 48;
   // Watchdog bound; a correct run stays well below it
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_FRAMES  = 52;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   logic [ID_W-1:0]          req_can_id = '0;
   logic [DLC_W-1:0]         req_length_code = '0;
   logic [DATA_W-1:0]        req_frame_data = '0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   logic [SLOT_W-1:0]        rsp_signal_slot;
   logic [DATA_W-1:0]        rsp_raw_value;
   logic signed [DATA_W-1:0] rsp_scaled_value;
   logic                     rsp_last;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CAL_W-1:0]         csr_data = '0;

   signal_book  book = new();
   bit          req_no_gap = 0;
   bit          rsp_no_stall = 0;
   int unsigned cycle_count = 0;

   can_signal_decoder_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_can_id       (req_can_id),
      .req_length_code  (req_length_code),
      .req_frame_data   (req_frame_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_signal_slot  (rsp_signal_slot),
      .rsp_raw_value    (rsp_raw_value),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // Watchdog: abandon the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Present one frame request and hold it until the block takes it. The
   // push line is only dropped when a gap is drawn, so back-to-back requests
   // never see a lower and a raise in the same step.
   task automatic push_frame(logic [ID_W-1:0] id, logic [DLC_W-1:0] dlc,
                             logic [DATA_W-1:0] data);
      int unsigned gap;
      gap = req_no_gap ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_can_id      <= id;
      req_length_code <= dlc;
      req_frame_data  <= data;
      do @(posedge clock); while (req_full);
      book.note_frame(id, dlc, data);
   endtask

   // Write one register; valid stays high so a burst of writes streams out.
   // The caller drops csr_valid once the burst is done.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CAL_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      book.write_reg(idx, data);
   endtask

   task automatic write_slot(int k, logic [CAL_W-1:0] def_word, logic [CAL_W-1:0] cal_word);
      write_reg(REG_DEF_BASE + CSR_IDX_W'(k), def_word);
      write_reg(CSR_CAL_BASE + CSR_IDX_W'(k), cal_word);
   endtask

   // Stop requesting, wait for every outstanding result, then let the back
   // end run dry: frames that match nothing leave no trace in the book.
   task automatic settle();
      req_push <= 1'b0;
      while (book.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CAL_W-1:0] make_def(bit en, bit big, int unsigned len,
                                                 int unsigned start, logic [ID_W-1:0] id);
      sig_def_type d;
      d.enable     = en;
      d.msb_first  = big;
      d.length     = LEN_W'(len);
      d.first_byte = BYTE_IDX_W'(start);
      d.can_id     = id;
      return {{(CAL_W-DEF_W){1'b0}}, d};
   endfunction

   function automatic logic [CAL_W-1:0] make_cal(logic [HALF_W-1:0] offset,
                                                 logic [HALF_W-1:0] scale);
      return {offset, scale};
   endfunction

   // Random slot definition: mostly signals that fit in a full frame, some
   // that overhang, a few disabled. Junk above bit 37 checks the masking.
   function automatic logic [CAL_W-1:0] random_def(logic [ID_W-1:0] id);
      sig_def_type d;
      d.can_id     = id;
      d.first_byte = BYTE_IDX_W'($urandom_range(0, DATA_BYTES - 1));
      if ($urandom_range(0, 9) < 8) begin
         d.length = LEN_W'($urandom_range(0, DATA_BYTES - d.first_byte));
      end else begin
         d.length = LEN_W'($urandom_range(0, 15));
      end
      d.msb_first  = 1'($urandom_range(0, 1));
      d.enable     = ($urandom_range(0, 9) < 8);
      return {(CAL_W-DEF_W)'($urandom), d};
   endfunction

   function automatic logic [CAL_W-1:0] random_cal();
      sig_cal_type c;
      case ($urandom_range(0, 3))
         0: c.scale = $urandom;
         1: c.scale = $urandom_range(0, 32'h0002_0000);
         2: c.scale = 32'h0001_0000;
         default: c.scale = $urandom_range(0, 255);
      endcase
      if ($urandom_range(0, 1)) begin
         c.offset = $urandom;
      end else begin
         c.offset = 32'($signed(18'($urandom)));
      end
      return c;
   endfunction

   // Result side: pop with a random stall per result, none in quiet phases
   initial begin : result_drain
      int unsigned stall;
      @(negedge reset);
      forever begin
         stall = rsp_no_stall ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         book.check_signal(rsp_signal_slot, rsp_raw_value, rsp_scaled_value, rsp_last);
      end
   end

   initial begin : frame_source
      logic [ID_W-1:0]   pool [2];
      logic [ID_W-1:0]   id;
      logic [DLC_W-1:0]  dlc;
      logic [CAL_W-1:0]  def_word;
      logic [CAL_W-1:0]  cal_word;
      int                ph;
      int                i;
      int                k;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset state: every slot disabled, so nothing may come out
      push_frame('0, 4'd8, {$urandom, $urandom});
      push_frame(ID_W'(12'h123), 4'd8, {$urandom, $urandom});
      settle();

      // Enable one slot only; its calibration must still be the reset 1.0 / 0
      write_reg(REG_DEF_BASE, make_def(1, 0, 8, 0, 29'h55));
      csr_valid <= 1'b0;
      push_frame(29'h55, 4'd8, 64'h0000_0000_0000_1234);
      settle();

      // Four slots on one identifier: big and little endian over the whole
      // frame, a zero-length signal, and a disabled overhanging slot.
      write_slot(0, make_def(1, 1, 8, 0, 29'h123), make_cal(32'h0, 32'h0001_0000));
      write_slot(1, make_def(1, 0, 8, 0, 29'h123), make_cal(32'h7FFF_FFFF, 32'hFFFF_FFFF));
      write_slot(2, make_def(1, 0, 0, 2, 29'h123), make_cal(32'h8000_0000, 32'h0000_0001));
      write_slot(3, make_def(0, 1, 15, 7, 29'h123), make_cal(32'h0, 32'h0001_0000));
      csr_valid <= 1'b0;
      push_frame(29'h123, 4'd8, '1);                       // saturating products
      push_frame(29'h123, 4'd15, 64'h0123_4567_89AB_CDEF); // length code clamps to 8
      push_frame(29'h123, 4'd0, '1);                       // empty frame: nothing fits
      push_frame(29'h123, 4'd2, {$urandom, $urandom});     // only the zero-length slot
      push_frame(29'h123, 4'd7, {$urandom, $urandom});     // whole-frame slots overhang
      push_frame(29'h122, 4'd8, {$urandom, $urandom});     // near miss on the identifier
      push_frame('0, 4'd8, '0);
      push_frame('1, 4'd8, '1);
      push_frame(29'h123, 4'd8, '0);                       // raw zero: offsets only
      push_frame(29'h123, 4'd8, 64'h1);
      settle();

      // Extreme identifiers, negative results and part-frame signals
      write_slot(0, make_def(1, 0, 2, 3, '0), make_cal(32'hFFFF_0000, 32'h0000_8000));
      write_slot(1, make_def(1, 1, 8, 0, '1), make_cal(32'h8000_0000, 32'hFFFF_FFFF));
      write_slot(2, make_def(1, 0, 1, 7, '1), make_cal(32'h7FFF_FFFF, 32'h0));
      write_slot(3, make_def(1, 0, 8, 0, '0), make_cal(32'h8000_0000, 32'h0001_0000));
      csr_valid <= 1'b0;
      push_frame('0, 4'd8, '0);
      push_frame('0, 4'd5, {$urandom, $urandom});          // slot 0 just fits
      push_frame('0, 4'd4, {$urandom, $urandom});          // slot 0 one byte short
      push_frame('1, 4'd8, '1);
      push_frame('1, 4'd8, 64'h8000_0000_0000_0000);
      push_frame('1, 4'd9, {$urandom, $urandom});
      push_frame('0, 4'd8, 64'h0000_0000_0000_FFFF);
      settle();

      // Random phases: each draws two identifiers and shares them among the
      // slots, so most frames hit one or more slots and some collide.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         pool[0] = ($urandom_range(0, 1)) ? ID_W'($urandom) : ID_W'($urandom_range(0, 12'h7FF));
         case (ph)
            0: pool[1] = '0;
            1: pool[1] = '1;
            default: pool[1] = ID_W'($urandom);
         endcase
         for (k = 0; k < SLOT_STORE; k++) begin
            def_word = random_def(pool[1'($urandom_range(0, 1))]);
            cal_word = random_cal();
            if (ph == 6) begin
               cal_word = '1;
            end
            if (ph == 7) begin
               cal_word = '0;
               if (k == 0) begin
                  def_word = '1;
               end
            end
            write_slot(k, def_word, cal_word);
         end
         csr_valid <= 1'b0;

         req_no_gap   = (ph % 4 == 1) || (ph % 4 == 3);
         rsp_no_stall = (ph % 4 == 1) || (ph % 4 == 2);

         for (i = 0; i < PHASE_FRAMES; i++) begin
            // hold off mid-phase once until the block has drained
            if (ph == 2 && i == PHASE_FRAMES / 2) begin
               settle();
            end
            id  = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) :
                                                pool[1'($urandom_range(0, 1))];
            dlc = ($urandom_range(0, 9) < 7) ? DLC_W'(8) : DLC_W'($urandom_range(0, 15));
            push_frame(id, dlc, {$urandom, $urandom});
         end
         settle();
      end

      if (book.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- can_signal_decoder_core.f -----
hdl/csd_pkg.sv
hdl/csd_fifo.sv
hdl/csd_front.sv
hdl/csd_back.sv
hdl/can_signal_decoder_core.sv
tb/can_signal_decoder_core_test.sv
